>>> design/gregorian_date_offset_and_difference_unit_assert.svh
// assertion macros shared by the date unit modules
`ifndef GREGORIAN_DATE_OFFSET_AND_DIFFERENCE_UNIT_ASSERT_SVH
`define GREGORIAN_DATE_OFFSET_AND_DIFFERENCE_UNIT_ASSERT_SVH

// same-cycle implication
`define GDODU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GDODU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/gdodu_pkg.sv
// ----------------------------------------------------------------------------
// gdodu_pkg
// Types, calendar constants and month tables for the Gregorian date unit.
// ----------------------------------------------------------------------------
package gdodu_pkg;

    localparam logic [21:0] DAYS_400    = 22'd146097;
    localparam logic [21:0] DAYS_100    = 22'd36524;
    localparam logic [21:0] DAYS_4      = 22'd1461;
    localparam logic [21:0] DAYS_1      = 22'd365;
    localparam logic [21:0] SERIAL_1900 = 22'd693595;
    localparam logic [21:0] SERIAL_LAST = 22'd3652058;
    localparam logic [13:0] YEAR_MAX    = 14'd9999;

    localparam logic [1:0] ORDER_EARLIER = 2'd0;
    localparam logic [1:0] ORDER_EQUAL   = 2'd1;
    localparam logic [1:0] ORDER_LATER   = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_B_INIT,
        ST_B_Q400,
        ST_B_Q100,
        ST_B_FIN,
        ST_O_INIT,
        ST_O_Q400,
        ST_O_Q100,
        ST_O_FIN,
        ST_N_INIT,
        ST_N_Q400,
        ST_N_Q100,
        ST_N_Q4,
        ST_N_Q1,
        ST_N_MON,
        ST_WRITE
    } state_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_CV_INIT,
        OP_CV_Q400,
        OP_CV_Q100,
        OP_CV_FIN,
        OP_N_INIT,
        OP_N_Q400,
        OP_N_Q100,
        OP_N_Q4,
        OP_N_Q1,
        OP_N_MON,
        OP_WRITE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   sel_other;
    } cmd_t;

    typedef struct packed {
        logic step_done;
        logic out_free;
        logic oor;
        logic mode;
    } sts_t;

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic leap, input logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        if (leap && m > 4'd2 && m <= 4'd12) begin
            n = n + 9'd1;
        end
        return n;
    endfunction

endpackage

>>> design/gregorian_date_offset_and_difference_unit.sv
// ----------------------------------------------------------------------------
// gregorian_date_offset_and_difference_unit
// Gregorian date arithmetic: add a signed day offset to a date, or give the
// signed day count and order between two dates.
// ----------------------------------------------------------------------------
// usage:
// s_ channel takes one request with mode, base date, day offset and other
// date; m_ channel returns one result per request, both valid/ready.
// the unit works on one request at a time; s_ready is high only when idle.
// each date is turned into a serial day by stepping 400 and 100 year
// cycles, one subtract per cycle.
// mode 1: base and other conversion, then the difference and order.
// mode 0: base conversion, then the sum is split into 400, 100, 4 and 1
// year steps and month steps; a sum outside the calendar skips the split.
// the result sits in an output register; the next request is accepted while
// it waits, and a stalled receiver only holds the unit at its final step.
// reset clears the sequencer and the output valid flag; no stored state
// is carried between requests.
// ----------------------------------------------------------------------------
module gregorian_date_offset_and_difference_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_mode,
    input  logic [13:0]         s_base_year,
    input  logic [3:0]          s_base_month,
    input  logic [4:0]          s_base_day,
    input  logic signed [22:0]  s_day_offset,
    input  logic [13:0]         s_other_year,
    input  logic [3:0]          s_other_month,
    input  logic [4:0]          s_other_day,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [13:0]         m_result_year,
    output logic [3:0]          m_result_month,
    output logic [4:0]          m_result_day,
    output logic signed [22:0]  m_day_difference,
    output logic [1:0]          m_date_order,
    output logic                m_base_was_invalid,
    output logic                m_out_of_range
);

    gdodu_pkg::cmd_t cmd;
    gdodu_pkg::sts_t sts;

    gdodu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gdodu_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .s_mode             (s_mode),
        .s_base_year        (s_base_year),
        .s_base_month       (s_base_month),
        .s_base_day         (s_base_day),
        .s_day_offset       (s_day_offset),
        .s_other_year       (s_other_year),
        .s_other_month      (s_other_month),
        .s_other_day        (s_other_day),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_result_year      (m_result_year),
        .m_result_month     (m_result_month),
        .m_result_day       (m_result_day),
        .m_day_difference   (m_day_difference),
        .m_date_order       (m_date_order),
        .m_base_was_invalid (m_base_was_invalid),
        .m_out_of_range     (m_out_of_range)
    );

endmodule

>>> design/gdodu_ctrl.sv
// ----------------------------------------------------------------------------
// gdodu_ctrl
// Sequencer for the date unit: converts the base date (and in difference mode
// the other date) to serial day numbers, then either splits the offset sum back into a date or forms the difference.
// ----------------------------------------------------------------------------
module gdodu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gdodu_pkg::sts_t   sts,
    output gdodu_pkg::cmd_t   cmd
);

    `include "gregorian_date_offset_and_difference_unit_assert.svh"

    gdodu_pkg::state_t state_reg;
    gdodu_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gdodu_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gdodu_pkg::ST_IDLE:   if (s_valid) state_next = gdodu_pkg::ST_B_INIT;
            gdodu_pkg::ST_B_INIT: state_next = gdodu_pkg::ST_B_Q400;
            gdodu_pkg::ST_B_Q400: if (sts.step_done) state_next = gdodu_pkg::ST_B_Q100;
            gdodu_pkg::ST_B_Q100: if (sts.step_done) state_next = gdodu_pkg::ST_B_FIN;
            gdodu_pkg::ST_B_FIN: begin
                state_next = sts.mode ? gdodu_pkg::ST_O_INIT : gdodu_pkg::ST_N_INIT;
            end
            gdodu_pkg::ST_O_INIT: state_next = gdodu_pkg::ST_O_Q400;
            gdodu_pkg::ST_O_Q400: if (sts.step_done) state_next = gdodu_pkg::ST_O_Q100;
            gdodu_pkg::ST_O_Q100: if (sts.step_done) state_next = gdodu_pkg::ST_O_FIN;
            gdodu_pkg::ST_O_FIN:  state_next = gdodu_pkg::ST_WRITE;
            gdodu_pkg::ST_N_INIT: state_next = gdodu_pkg::ST_N_Q400;
            gdodu_pkg::ST_N_Q400: begin
                if (sts.oor) begin
                    state_next = gdodu_pkg::ST_WRITE;
                end else if (sts.step_done) begin
                    state_next = gdodu_pkg::ST_N_Q100;
                end
            end
            gdodu_pkg::ST_N_Q100: if (sts.step_done) state_next = gdodu_pkg::ST_N_Q4;
            gdodu_pkg::ST_N_Q4:   if (sts.step_done) state_next = gdodu_pkg::ST_N_Q1;
            gdodu_pkg::ST_N_Q1:   if (sts.step_done) state_next = gdodu_pkg::ST_N_MON;
            gdodu_pkg::ST_N_MON:  if (sts.step_done) state_next = gdodu_pkg::ST_WRITE;
            gdodu_pkg::ST_WRITE:  if (sts.out_free) state_next = gdodu_pkg::ST_IDLE;
            default:              state_next = gdodu_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op        = gdodu_pkg::OP_IDLE;
        cmd.sel_other = 1'b0;
        s_ready       = 1'b0;
        case (state_reg)
            gdodu_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                cmd.op  = s_valid ? gdodu_pkg::OP_LOAD : gdodu_pkg::OP_IDLE;
            end
            gdodu_pkg::ST_B_INIT: cmd.op = gdodu_pkg::OP_CV_INIT;
            gdodu_pkg::ST_B_Q400: cmd.op = gdodu_pkg::OP_CV_Q400;
            gdodu_pkg::ST_B_Q100: cmd.op = gdodu_pkg::OP_CV_Q100;
            gdodu_pkg::ST_B_FIN:  cmd.op = gdodu_pkg::OP_CV_FIN;
            gdodu_pkg::ST_O_INIT: begin
                cmd.op        = gdodu_pkg::OP_CV_INIT;
                cmd.sel_other = 1'b1;
            end
            gdodu_pkg::ST_O_Q400: begin
                cmd.op        = gdodu_pkg::OP_CV_Q400;
                cmd.sel_other = 1'b1;
            end
            gdodu_pkg::ST_O_Q100: begin
                cmd.op        = gdodu_pkg::OP_CV_Q100;
                cmd.sel_other = 1'b1;
            end
            gdodu_pkg::ST_O_FIN: begin
                cmd.op        = gdodu_pkg::OP_CV_FIN;
                cmd.sel_other = 1'b1;
            end
            gdodu_pkg::ST_N_INIT: cmd.op = gdodu_pkg::OP_N_INIT;
            gdodu_pkg::ST_N_Q400: cmd.op = gdodu_pkg::OP_N_Q400;
            gdodu_pkg::ST_N_Q100: cmd.op = gdodu_pkg::OP_N_Q100;
            gdodu_pkg::ST_N_Q4:   cmd.op = gdodu_pkg::OP_N_Q4;
            gdodu_pkg::ST_N_Q1:   cmd.op = gdodu_pkg::OP_N_Q1;
            gdodu_pkg::ST_N_MON:  cmd.op = gdodu_pkg::OP_N_MON;
            gdodu_pkg::ST_WRITE:  cmd.op = gdodu_pkg::OP_WRITE;
            default:              cmd.op = gdodu_pkg::OP_IDLE;
        endcase
    end

    `GDODU_ASSERT_NEXT(a_accept_starts_base, aclk, aresetn, s_valid && s_ready, state_reg == gdodu_pkg::ST_B_INIT, "accepted request did not start base conversion")

endmodule

>>> design/gdodu_dp.sv
// ----------------------------------------------------------------------------
// gdodu_dp
// Datapath for the date unit: request registers, serial day conversion by
// repeated subtraction of 400 and 100 year cycles, date split of the offset
// sum, day difference and order, and the output register.
// ----------------------------------------------------------------------------
module gdodu_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  gdodu_pkg::cmd_t     cmd,
    output gdodu_pkg::sts_t     sts,
    input  logic                s_mode,
    input  logic [13:0]         s_base_year,
    input  logic [3:0]          s_base_month,
    input  logic [4:0]          s_base_day,
    input  logic signed [22:0]  s_day_offset,
    input  logic [13:0]         s_other_year,
    input  logic [3:0]          s_other_month,
    input  logic [4:0]          s_other_day,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [13:0]         m_result_year,
    output logic [3:0]          m_result_month,
    output logic [4:0]          m_result_day,
    output logic signed [22:0]  m_day_difference,
    output logic [1:0]          m_date_order,
    output logic                m_base_was_invalid,
    output logic                m_out_of_range
);

    `include "gregorian_date_offset_and_difference_unit_assert.svh"

    // request registers
    logic               mode_reg, mode_next;
    logic [13:0]        by_reg, by_next, oy_reg, oy_next;
    logic [3:0]         bm_reg, bm_next, om_reg, om_next;
    logic [4:0]         bd_reg, bd_next, od_reg, od_next;
    logic signed [22:0] off_reg, off_next;

    // work registers
    logic [13:0] p_reg, p_next;
    logic [21:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [21:0] base_ser_reg, base_ser_next;
    logic [21:0] oth_ser_reg, oth_ser_next;
    logic        inv_reg, inv_next;
    logic [21:0] r_reg, r_next;
    logic [13:0] year_reg, year_next;
    logic [4:0]  q4_reg, q4_next;
    logic [1:0]  q1_reg, q1_next;
    logic [3:0]  mon_reg, mon_next;
    logic        oor_reg, oor_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [13:0]        out_year_reg, out_year_next;
    logic [3:0]         out_month_reg, out_month_next;
    logic [4:0]         out_day_reg, out_day_next;
    logic signed [22:0] out_diff_reg, out_diff_next;
    logic [1:0]         out_order_reg, out_order_next;
    logic               out_inv_reg, out_inv_next;
    logic               out_oor_reg, out_oor_next;

    logic [13:0]        cur_y;
    logic [3:0]         cur_m;
    logic [4:0]         cur_d;
    logic               cv_leap;
    logic               cv_valid;
    logic [21:0]        cv_serial;
    logic [21:0]        cv_ser_final;
    logic signed [24:0] n_sum;
    logic               n_oor;
    logic               n_leap;
    logic [4:0]         mlen_cur;
    logic signed [22:0] diff_w;
    logic               go;
    logic               out_free;

    assign cur_y = cmd.sel_other ? oy_reg : by_reg;
    assign cur_m = cmd.sel_other ? om_reg : bm_reg;
    assign cur_d = cmd.sel_other ? od_reg : bd_reg;

    // p holds (year-1) mod 100 here, cnt the count of 100 year steps
    assign cv_leap  = (p_reg[1:0] == 2'd3) && ((p_reg != 14'd99) || (cnt_reg == 2'd3));
    assign cv_valid = (cur_y >= 14'd1) && (cur_y <= gdodu_pkg::YEAR_MAX)
                   && (cur_m >= 4'd1) && (cur_m <= 4'd12)
                   && (cur_d >= 5'd1) && (cur_d <= gdodu_pkg::month_len(cv_leap, cur_m));
    assign cv_serial = acc_reg
                     + 22'(p_reg[6:2]) * gdodu_pkg::DAYS_4
                     + 22'(p_reg[1:0]) * gdodu_pkg::DAYS_1
                     + 22'(gdodu_pkg::days_before(cv_leap, cur_m))
                     + 22'(cur_d) - 22'd1;
    assign cv_ser_final = cv_valid ? cv_serial : gdodu_pkg::SERIAL_1900;

    assign n_sum = $signed({3'b000, base_ser_reg}) + $signed({{2{off_reg[22]}}, off_reg});
    assign n_oor = n_sum[24] || (n_sum[23:0] > {2'b00, gdodu_pkg::SERIAL_LAST});

    assign n_leap   = (q1_reg == 2'd3) && ((q4_reg != 5'd24) || (cnt_reg == 2'd3));
    assign mlen_cur = gdodu_pkg::month_len(n_leap, mon_reg);

    assign diff_w = $signed({1'b0, base_ser_reg}) - $signed({1'b0, oth_ser_reg});

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        case (cmd.op)
            gdodu_pkg::OP_CV_Q400: go = (p_reg >= 14'd400);
            gdodu_pkg::OP_CV_Q100: go = (p_reg >= 14'd100);
            gdodu_pkg::OP_N_Q400:  go = (r_reg >= gdodu_pkg::DAYS_400);
            gdodu_pkg::OP_N_Q100:  go = (r_reg >= gdodu_pkg::DAYS_100) && (cnt_reg != 2'd3);
            gdodu_pkg::OP_N_Q4:    go = (r_reg >= gdodu_pkg::DAYS_4);
            gdodu_pkg::OP_N_Q1:    go = (r_reg >= gdodu_pkg::DAYS_1) && (q1_reg != 2'd3);
            gdodu_pkg::OP_N_MON:   go = (mon_reg != 4'd12) && (r_reg >= 22'(mlen_cur));
            default:               go = 1'b0;
        endcase
    end

    assign sts.step_done = !go;
    assign sts.out_free  = out_free;
    assign sts.oor       = oor_reg;
    assign sts.mode      = mode_reg;

    always_comb begin
        mode_next      = mode_reg;
        by_next        = by_reg;
        bm_next        = bm_reg;
        bd_next        = bd_reg;
        off_next       = off_reg;
        oy_next        = oy_reg;
        om_next        = om_reg;
        od_next        = od_reg;
        p_next         = p_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        base_ser_next  = base_ser_reg;
        oth_ser_next   = oth_ser_reg;
        inv_next       = inv_reg;
        r_next         = r_reg;
        year_next      = year_reg;
        q4_next        = q4_reg;
        q1_next        = q1_reg;
        mon_next       = mon_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_year_next  = out_year_reg;
        out_month_next = out_month_reg;
        out_day_next   = out_day_reg;
        out_diff_next  = out_diff_reg;
        out_order_next = out_order_reg;
        out_inv_next   = out_inv_reg;
        out_oor_next   = out_oor_reg;

        case (cmd.op)
            gdodu_pkg::OP_LOAD: begin
                mode_next = s_mode;
                by_next   = s_base_year;
                bm_next   = s_base_month;
                bd_next   = s_base_day;
                off_next  = s_day_offset;
                oy_next   = s_other_year;
                om_next   = s_other_month;
                od_next   = s_other_day;
            end
            gdodu_pkg::OP_CV_INIT: begin
                p_next   = cur_y - 14'd1;
                acc_next = '0;
                cnt_next = '0;
            end
            gdodu_pkg::OP_CV_Q400: begin
                if (go) begin
                    p_next   = p_reg - 14'd400;
                    acc_next = acc_reg + gdodu_pkg::DAYS_400;
                end
            end
            gdodu_pkg::OP_CV_Q100: begin
                if (go) begin
                    p_next   = p_reg - 14'd100;
                    acc_next = acc_reg + gdodu_pkg::DAYS_100;
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            gdodu_pkg::OP_CV_FIN: begin
                if (cmd.sel_other) begin
                    oth_ser_next = cv_ser_final;
                end else begin
                    base_ser_next = cv_ser_final;
                    inv_next      = !cv_valid;
                end
            end
            gdodu_pkg::OP_N_INIT: begin
                r_next    = n_sum[21:0];
                oor_next  = n_oor;
                year_next = 14'd1;
                cnt_next  = '0;
                q4_next   = '0;
                q1_next   = '0;
                mon_next  = 4'd1;
            end
            gdodu_pkg::OP_N_Q400: begin
                if (go) begin
                    r_next    = r_reg - gdodu_pkg::DAYS_400;
                    year_next = year_reg + 14'd400;
                end
            end
            gdodu_pkg::OP_N_Q100: begin
                if (go) begin
                    r_next    = r_reg - gdodu_pkg::DAYS_100;
                    year_next = year_reg + 14'd100;
                    cnt_next  = cnt_reg + 2'd1;
                end
            end
            gdodu_pkg::OP_N_Q4: begin
                if (go) begin
                    r_next    = r_reg - gdodu_pkg::DAYS_4;
                    year_next = year_reg + 14'd4;
                    q4_next   = q4_reg + 5'd1;
                end
            end
            gdodu_pkg::OP_N_Q1: begin
                if (go) begin
                    r_next    = r_reg - gdodu_pkg::DAYS_1;
                    year_next = year_reg + 14'd1;
                    q1_next   = q1_reg + 2'd1;
                end
            end
            gdodu_pkg::OP_N_MON: begin
                if (go) begin
                    r_next   = r_reg - 22'(mlen_cur);
                    mon_next = mon_reg + 4'd1;
                end
            end
            gdodu_pkg::OP_WRITE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_inv_next   = inv_reg;
                    out_year_next  = '0;
                    out_month_next = '0;
                    out_day_next   = '0;
                    out_diff_next  = '0;
                    out_order_next = gdodu_pkg::ORDER_EARLIER;
                    out_oor_next   = 1'b0;
                    if (!mode_reg) begin
                        if (oor_reg) begin
                            out_oor_next = 1'b1;
                        end else begin
                            out_year_next  = year_reg;
                            out_month_next = mon_reg;
                            out_day_next   = r_reg[4:0] + 5'd1;
                        end
                    end else begin
                        out_diff_next = diff_w;
                        if (diff_w < 0) begin
                            out_order_next = gdodu_pkg::ORDER_EARLIER;
                        end else if (diff_w == 0) begin
                            out_order_next = gdodu_pkg::ORDER_EQUAL;
                        end else begin
                            out_order_next = gdodu_pkg::ORDER_LATER;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        by_reg        <= by_next;
        bm_reg        <= bm_next;
        bd_reg        <= bd_next;
        off_reg       <= off_next;
        oy_reg        <= oy_next;
        om_reg        <= om_next;
        od_reg        <= od_next;
        p_reg         <= p_next;
        acc_reg       <= acc_next;
        cnt_reg       <= cnt_next;
        base_ser_reg  <= base_ser_next;
        oth_ser_reg   <= oth_ser_next;
        inv_reg       <= inv_next;
        r_reg         <= r_next;
        year_reg      <= year_next;
        q4_reg        <= q4_next;
        q1_reg        <= q1_next;
        mon_reg       <= mon_next;
        oor_reg       <= oor_next;
        out_year_reg  <= out_year_next;
        out_month_reg <= out_month_next;
        out_day_reg   <= out_day_next;
        out_diff_reg  <= out_diff_next;
        out_order_reg <= out_order_next;
        out_inv_reg   <= out_inv_next;
        out_oor_reg   <= out_oor_next;
    end

    assign m_valid            = out_valid_reg;
    assign m_result_year      = out_year_reg;
    assign m_result_month     = out_month_reg;
    assign m_result_day       = out_day_reg;
    assign m_day_difference   = out_diff_reg;
    assign m_date_order       = out_order_reg;
    assign m_base_was_invalid = out_inv_reg;
    assign m_out_of_range     = out_oor_reg;

    `GDODU_ASSERT_NOW(a_month_in_range, aclk, aresetn, cmd.op == gdodu_pkg::OP_N_MON, mon_reg >= 4'd1 && mon_reg <= 4'd12, "month walk left January to December")
    `GDODU_ASSERT_NOW(a_century_rest, aclk, aresetn, cmd.op == gdodu_pkg::OP_N_Q4, r_reg < 22'd36525, "day rest too large after century steps")
    `GDODU_ASSERT_NEXT(a_date_nonzero, aclk, aresetn, cmd.op == gdodu_pkg::OP_WRITE && out_free && !mode_reg && !oor_reg, m_result_year != 14'd0 && m_result_month != 4'd0 && m_result_day != 5'd0, "in-range date result has a zero field")

endmodule

>>> dv/tb_gregorian_date_offset_and_difference_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gregorian_date_offset_and_difference_unit
// Self-checking testbench for the Gregorian date unit. A directed table covers
// calendar extremes, leap days, invalid dates and range overflow, then random
// add and difference requests follow. Every result is compared field by field
// with a fixed expected row or a calendar model kept in the testbench, under random idling on both
// valid/ready channels.
// ----------------------------------------------------------------------------
module tb_gregorian_date_offset_and_difference_unit;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_DIFF = 1'b1;

    localparam int RANDOM_REQUESTS = 600;
    localparam int IDLE_PCT        = 35;
    localparam int DRAIN_CYCLES    = 150;
    localparam int CYCLE_LIMIT     = 1000000;

    typedef struct {
        logic               mode;
        logic [13:0]        base_year;
        logic [3:0]         base_month;
        logic [4:0]         base_day;
        logic signed [22:0] day_offset;
        logic [13:0]        other_year;
        logic [3:0]         other_month;
        logic [4:0]         other_day;
    } date_request_t;

    typedef struct {
        logic [13:0]        result_year;
        logic [3:0]         result_month;
        logic [4:0]         result_day;
        logic signed [22:0] day_difference;
        logic [1:0]         date_order;
        logic               base_was_invalid;
        logic               out_of_range;
    } date_result_t;

    typedef struct {
        date_request_t req;
        bit            fixed;
        date_result_t  res;
    } stim_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_mode = 1'b0;
    logic [13:0]        s_base_year = '0;
    logic [3:0]         s_base_month = '0;
    logic [4:0]         s_base_day = '0;
    logic signed [22:0] s_day_offset = '0;
    logic [13:0]        s_other_year = '0;
    logic [3:0]         s_other_month = '0;
    logic [4:0]         s_other_day = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [13:0]        m_result_year;
    logic [3:0]         m_result_month;
    logic [4:0]         m_result_day;
    logic signed [22:0] m_day_difference;
    logic [1:0]         m_date_order;
    logic               m_base_was_invalid;
    logic               m_out_of_range;

    date_result_t pending_results[$];
    stim_row_t    stim_table[$];
    bit           quiet_run = 1'b0;
    int           error_count = 0;
    int           cycle_count = 0;
    int           add_count = 0;
    int           diff_count = 0;
    int           invalid_count = 0;
    int           overflow_count = 0;

    gregorian_date_offset_and_difference_unit uut (.*);

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // calendar model
    // ------------------------------------------------------------------
    function automatic bit is_leap_year(input longint y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic longint days_in_month(input longint y, input longint m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic longint first_day_of_year(input longint y);
        longint p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic longint day_serial(input longint y, input longint m, input longint d);
        longint n;
        n = first_day_of_year(y);
        for (longint k = 1; k < m; k++) begin
            n += days_in_month(y, k);
        end
        return n + d - 1;
    endfunction

    function automatic bit date_is_valid(input longint y, input longint m, input longint d);
        if (y < 1 || y > 9999 || m < 1 || m > 12) begin
            return 1'b0;
        end
        return d >= 1 && d <= days_in_month(y, m);
    endfunction

    function automatic date_result_t predict_date_result(input date_request_t r);
        date_result_t res;
        longint by, bm, bd, oy, om, od, off, base, n, year_end, y, m;
        res = '{default: '0};
        by = longint'(r.base_year);
        bm = longint'(r.base_month);
        bd = longint'(r.base_day);
        oy = longint'(r.other_year);
        om = longint'(r.other_month);
        od = longint'(r.other_day);
        off = longint'(r.day_offset);
        if (!date_is_valid(by, bm, bd)) begin
            by = 1900;
            bm = 1;
            bd = 1;
            res.base_was_invalid = 1'b1;
        end
        if (!date_is_valid(oy, om, od)) begin
            oy = 1900;
            om = 1;
            od = 1;
        end
        base = day_serial(by, bm, bd);
        if (r.mode == MODE_ADD) begin
            n = base + off;
            year_end = first_day_of_year(10000) - 1;
            if (n < 0 || n > year_end) begin
                res.out_of_range = 1'b1;
            end else begin
                y = (n * 400) / 146097 + 1;
                if (y > 9999) begin
                    y = 9999;
                end
                while (y > 1 && first_day_of_year(y) > n) begin
                    y--;
                end
                while (y < 9999 && first_day_of_year(y + 1) <= n) begin
                    y++;
                end
                n -= first_day_of_year(y);
                m = 1;
                while (m < 12 && n >= days_in_month(y, m)) begin
                    n -= days_in_month(y, m);
                    m++;
                end
                res.result_year = 14'(y);
                res.result_month = 4'(m);
                res.result_day = 5'(n + 1);
            end
        end else begin
            n = base - day_serial(oy, om, od);
            res.day_difference = 23'(n);
            res.date_order = (n < 0) ? gdodu_pkg::ORDER_EARLIER :
                             ((n == 0) ? gdodu_pkg::ORDER_EQUAL : gdodu_pkg::ORDER_LATER);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic date_request_t make_req(input logic mode, input int by, input int bm,
                                               input int bd, input int off, input int oy,
                                               input int om, input int od);
        date_request_t r;
        r.mode = mode;
        r.base_year = 14'(by);
        r.base_month = 4'(bm);
        r.base_day = 5'(bd);
        r.day_offset = 23'(off);
        r.other_year = 14'(oy);
        r.other_month = 4'(om);
        r.other_day = 5'(od);
        return r;
    endfunction

    function automatic date_result_t make_res(input int y, input int m, input int d,
                                              input int diff, input logic [1:0] order,
                                              input logic inv, input logic oor);
        date_result_t r;
        r.result_year = 14'(y);
        r.result_month = 4'(m);
        r.result_day = 5'(d);
        r.day_difference = 23'(diff);
        r.date_order = order;
        r.base_was_invalid = inv;
        r.out_of_range = oor;
        return r;
    endfunction

    function automatic void add_row(input date_request_t req, input bit fixed,
                                    input date_result_t res);
        stim_row_t row;
        row.req = req;
        row.fixed = fixed;
        row.res = res;
        stim_table.push_back(row);
    endfunction

    function automatic void pick_date(output logic [13:0] y, output logic [3:0] m,
                                      output logic [4:0] d);
        int yy;
        int mm;
        if ($urandom_range(99) < 12) begin
            y = 14'($urandom_range(0, 16383));
            m = 4'($urandom_range(0, 15));
            d = 5'($urandom_range(0, 31));
        end else begin
            case ($urandom_range(0, 7))
                0:       yy = $urandom_range(1, 4);
                1:       yy = $urandom_range(9996, 9999);
                2:       yy = 100 * $urandom_range(1, 99) + $urandom_range(0, 2) - 1;
                default: yy = $urandom_range(1, 9999);
            endcase
            mm = $urandom_range(1, 12);
            y = 14'(yy);
            m = 4'(mm);
            d = 5'($urandom_range(1, 32'(days_in_month(yy, mm))));
        end
    endfunction

    function automatic date_request_t random_request();
        date_request_t r;
        int off;
        r.mode = 1'($urandom_range(0, 1));
        pick_date(r.base_year, r.base_month, r.base_day);
        pick_date(r.other_year, r.other_month, r.other_day);
        case ($urandom_range(0, 5))
            0:       off = int'($urandom_range(0, 62)) - 31;
            1:       off = int'($urandom_range(0, 800)) - 400;
            2:       off = int'($urandom_range(0, 80000)) - 40000;
            3:       off = int'($urandom_range(0, 7400000)) - 3700000;
            4:       off = int'($urandom & 32'h007f_ffff) - 4194304;
            default: off = ($urandom_range(0, 1) == 0) ? -4194304 : 4194303;
        endcase
        r.day_offset = 23'(off);
        return r;
    endfunction

    task automatic send_date_request(input date_request_t req, input bit fixed,
                                     input date_result_t fixed_res);
        date_result_t want;
        while (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= req.mode;
        s_base_year <= req.base_year;
        s_base_month <= req.base_month;
        s_base_day <= req.base_day;
        s_day_offset <= req.day_offset;
        s_other_year <= req.other_year;
        s_other_month <= req.other_month;
        s_other_day <= req.other_day;
        do @(posedge aclk); while (!s_ready);
        want = fixed ? fixed_res : predict_date_result(req);
        pending_results.push_back(want);
        if (req.mode == MODE_ADD) begin
            add_count++;
        end else begin
            diff_count++;
        end
        invalid_count += want.base_was_invalid;
        overflow_count += want.out_of_range;
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input longint want, input longint got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        error_count++;
    endtask

    task automatic check_date_result();
        date_result_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: result with no request outstanding", $time);
            error_count++;
        end else begin
            want = pending_results.pop_front();
            if (m_result_year !== want.result_year)
                report_mismatch("result_year", want.result_year, m_result_year);
            if (m_result_month !== want.result_month)
                report_mismatch("result_month", want.result_month, m_result_month);
            if (m_result_day !== want.result_day)
                report_mismatch("result_day", want.result_day, m_result_day);
            if (m_day_difference !== want.day_difference)
                report_mismatch("day_difference", want.day_difference, m_day_difference);
            if (m_date_order !== want.date_order)
                report_mismatch("date_order", want.date_order, m_date_order);
            if (m_base_was_invalid !== want.base_was_invalid)
                report_mismatch("base_was_invalid", want.base_was_invalid, m_base_was_invalid);
            if (m_out_of_range !== want.out_of_range)
                report_mismatch("out_of_range", want.out_of_range, m_out_of_range);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_date_result();
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet_run || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        date_result_t none;
        none = '{default: '0};

        // leap day, calendar ends, range overflow
        add_row(make_req(MODE_ADD, 2000, 2, 29, 0, 1, 1, 1), 1,
                make_res(2000, 2, 29, 0, gdodu_pkg::ORDER_EARLIER, 0, 0));
        add_row(make_req(MODE_ADD, 1, 1, 1, 0, 9999, 12, 31), 1,
                make_res(1, 1, 1, 0, gdodu_pkg::ORDER_EARLIER, 0, 0));
        add_row(make_req(MODE_ADD, 1, 1, 1, -1, 1, 1, 1), 1,
                make_res(0, 0, 0, 0, gdodu_pkg::ORDER_EARLIER, 0, 1));
        add_row(make_req(MODE_ADD, 9999, 12, 31, 0, 1, 1, 1), 1,
                make_res(9999, 12, 31, 0, gdodu_pkg::ORDER_EARLIER, 0, 0));
        add_row(make_req(MODE_ADD, 9999, 12, 31, 1, 1, 1, 1), 1,
                make_res(0, 0, 0, 0, gdodu_pkg::ORDER_EARLIER, 0, 1));
        // invalid base dates fall back to 1900-01-01
        add_row(make_req(MODE_ADD, 2023, 0, 10, 0, 1, 1, 1), 1,
                make_res(1900, 1, 1, 0, gdodu_pkg::ORDER_EARLIER, 1, 0));
        add_row(make_req(MODE_ADD, 2023, 5, 0, 0, 1, 1, 1), 1,
                make_res(1900, 1, 1, 0, gdodu_pkg::ORDER_EARLIER, 1, 0));
        add_row(make_req(MODE_ADD, 0, 1, 1, 0, 1, 1, 1), 1,
                make_res(1900, 1, 1, 0, gdodu_pkg::ORDER_EARLIER, 1, 0));
        add_row(make_req(MODE_ADD, 16383, 15, 31, 0, 16383, 15, 31), 1,
                make_res(1900, 1, 1, 0, gdodu_pkg::ORDER_EARLIER, 1, 0));
        add_row(make_req(MODE_ADD, 1900, 2, 29, 0, 1, 1, 1), 1,
                make_res(1900, 1, 1, 0, gdodu_pkg::ORDER_EARLIER, 1, 0));
        add_row(make_req(MODE_ADD, 2100, 2, 29, 0, 1, 1, 1), 1,
                make_res(1900, 1, 1, 0, gdodu_pkg::ORDER_EARLIER, 1, 0));
        add_row(make_req(MODE_ADD, 2023, 4, 31, 1, 1, 1, 1), 1,
                make_res(1900, 1, 2, 0, gdodu_pkg::ORDER_EARLIER, 1, 0));
        // offset extremes and month/year rollover
        add_row(make_req(MODE_ADD, 1999, 12, 31, 1, 1, 1, 1), 0, none);
        add_row(make_req(MODE_ADD, 2024, 3, 1, -1, 1, 1, 1), 0, none);
        add_row(make_req(MODE_ADD, 1, 1, 1, 4194303, 1, 1, 1), 0, none);
        add_row(make_req(MODE_ADD, 9999, 12, 31, -4194304, 1, 1, 1), 0, none);
        add_row(make_req(MODE_ADD, 9999, 12, 31, -3652058, 1, 1, 1), 0, none);
        add_row(make_req(MODE_ADD, 2400, 2, 28, 1, 16383, 15, 31), 0, none);
        // differences: equal, full span both ways, invalid dates
        add_row(make_req(MODE_DIFF, 2024, 7, 4, 4194303, 2024, 7, 4), 1,
                make_res(0, 0, 0, 0, gdodu_pkg::ORDER_EQUAL, 0, 0));
        add_row(make_req(MODE_DIFF, 9999, 12, 31, -4194304, 1, 1, 1), 1,
                make_res(0, 0, 0, 3652058, gdodu_pkg::ORDER_LATER, 0, 0));
        add_row(make_req(MODE_DIFF, 1, 1, 1, 0, 9999, 12, 31), 1,
                make_res(0, 0, 0, -3652058, gdodu_pkg::ORDER_EARLIER, 0, 0));
        add_row(make_req(MODE_DIFF, 1900, 1, 2, 0, 2023, 13, 1), 1,
                make_res(0, 0, 0, 1, gdodu_pkg::ORDER_LATER, 0, 0));
        add_row(make_req(MODE_DIFF, 2023, 2, 30, 0, 1900, 1, 1), 1,
                make_res(0, 0, 0, 0, gdodu_pkg::ORDER_EQUAL, 1, 0));
        add_row(make_req(MODE_DIFF, 2000, 3, 1, 0, 1900, 3, 1), 0, none);
        add_row(make_req(MODE_DIFF, 1600, 2, 29, 0, 2400, 12, 31), 0, none);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[i]) begin
            send_date_request(stim_table[i].req, stim_table[i].fixed, stim_table[i].res);
        end

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            // back-to-back stretch with both sides always ready
            quiet_run = (i >= 200 && i < 300);
            send_date_request(random_request(), 0, none);
        end
        quiet_run = 1'b0;
        s_valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests checked: %0d add, %0d difference", add_count + diff_count,
                 add_count, diff_count);
        $display("%0d with an invalid base date, %0d past the calendar range, %0d mismatches",
                 invalid_count, overflow_count, error_count);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
